FILE: hdl/iroot_pkg.sv
// shared constants and types for the integer root block
package iroot_pkg;

    localparam int VALUE_BITS     = 256;
    localparam int MAX_ITERATIONS = 20;
    localparam int STARTING_BITS  = 8;

    localparam int IN_WORD_BITS = 64;
    localparam int ROOT_BITS    = 128;
    localparam int DEG_BITS     = 4;
    localparam int CNT_W        = $clog2(VALUE_BITS) + 1;
    localparam int IT_W         = $clog2(MAX_ITERATIONS + 1);
    localparam int SB_W         = $clog2(STARTING_BITS + 1);

    localparam logic [DEG_BITS-1:0] DEG_MIN = DEG_BITS'(2);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RBITS,
        ST_SHR,
        ST_SEARCH,
        ST_POW_MUL,
        ST_POW_CHK,
        ST_SHL,
        ST_DEN_INIT,
        ST_DEN_MUL,
        ST_DIV_Q,
        ST_CMP,
        ST_STEP,
        ST_DIV_D,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        TERM_NONE,
        TERM_UP,
        TERM_DOWN
    } term_t;

endpackage

FILE: hdl/integer_nth_root.sv
// integer nth root of a 256-bit operand: bitwise seed search and Newton refinement
// seed search of up to 8 bits on the shared bit-serial unit, after the bit-length scan
//   and a right shift, followed by a left shift; at most 20 Newton steps; a zero
//   operand goes straight to the finish state, which registers the result once the
//   output is free
// throughput: one item at a time; the next item is taken once the result is registered
// reset: asynchronous, active low; clears control state and sets the stored degree to 2
module integer_nth_root
    import iroot_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [DEG_BITS-1:0]     root_degree,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [IN_WORD_BITS-1:0] value_word0,
    input  logic [IN_WORD_BITS-1:0] value_word1,
    input  logic [IN_WORD_BITS-1:0] value_word2,
    input  logic [IN_WORD_BITS-1:0] value_word3,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [IN_WORD_BITS-1:0] root_low,
    output logic [IN_WORD_BITS-1:0] root_high,
    output logic                    divide_fault
);

    localparam int VB = VALUE_BITS;

    state_t                state_reg, state_next;
    term_t                 term_reg, term_next;
    logic [DEG_BITS-1:0]   cfg_deg_reg;
    logic [DEG_BITS-1:0]   deg_reg, deg_next;
    logic [VB-1:0]         bn_reg, bn_next;
    logic [VB-1:0]         cur_reg, cur_next;
    logic [VB-1:0]         acc_reg, acc_next;
    logic [VB-1:0]         opa_reg, opa_next;
    logic [VB-1:0]         opb_reg, opb_next;
    logic [VB-1:0]         quo_reg, quo_next;
    logic [VB-1:0]         upper_reg, upper_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      bits_reg, bits_next;
    logic [CNT_W-1:0]      rbits_reg, rbits_next;
    logic [SB_W-1:0]       sbits_reg, sbits_next;
    logic [SB_W-1:0]       k_reg, k_next;
    logic [DEG_BITS-1:0]   j_reg, j_next;
    logic [IT_W-1:0]       it_reg, it_next;
    logic                  dir_reg, dir_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ROOT_BITS-1:0]  res_reg, res_next;
    logic                  fault_reg, fault_next;

    logic [4*IN_WORD_BITS-1:0] in_cat;
    logic [VB-1:0]         mul_step;
    logic [VB-1:0]         div_sh;
    logic                  div_ge;
    logic [VB-1:0]         div_rem;
    logic [VB-1:0]         div_quo;
    logic [VB-1:0]         deg_ext;
    logic [VB-1:0]         pow_cur;
    logic [SB_W-1:0]       sb_min;
    logic [2*CNT_W-1:0]    amt_wide;
    logic [4*IN_WORD_BITS-1:0] cur_wide;
    logic                  out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign root_low  = res_reg[IN_WORD_BITS-1:0];
    assign root_high = res_reg[ROOT_BITS-1:IN_WORD_BITS];
    assign divide_fault = fault_reg;

    assign in_cat  = {value_word3, value_word2, value_word1, value_word0};
    assign deg_ext = VB'(deg_reg);
    assign cur_wide = (4*IN_WORD_BITS)'(cur_reg);
    assign out_free = !out_valid_reg || out_ready;

    // shared bit-serial unit: multiply by shift-add, restoring divide
    assign mul_step = {acc_reg[VB-2:0], 1'b0} + (opb_reg[VB-1] ? opa_reg : '0);
    assign div_sh   = {acc_reg[VB-2:0], opb_reg[VB-1]};
    assign div_ge   = acc_reg[VB-1] || (div_sh >= opa_reg);
    assign div_rem  = div_ge ? (div_sh - opa_reg) : div_sh;
    assign div_quo  = {quo_reg[VB-2:0], div_ge};

    assign pow_cur  = (acc_reg <= upper_reg) ? opa_reg : cur_reg;
    assign sb_min   = (rbits_reg < CNT_W'(STARTING_BITS)) ? SB_W'(rbits_reg)
                                                           : SB_W'(STARTING_BITS);
    assign amt_wide = (2*CNT_W)'(rbits_reg - CNT_W'(sb_min)) * (2*CNT_W)'(deg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            term_reg      <= TERM_NONE;
            cfg_deg_reg   <= DEG_MIN;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            it_reg        <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            it_reg        <= it_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_deg_reg <= root_degree;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        deg_reg   <= deg_next;
        bn_reg    <= bn_next;
        cur_reg   <= cur_next;
        acc_reg   <= acc_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        quo_reg   <= quo_next;
        upper_reg <= upper_next;
        bits_reg  <= bits_next;
        rbits_reg <= rbits_next;
        sbits_reg <= sbits_next;
        dir_reg   <= dir_next;
        res_reg   <= res_next;
        fault_reg <= fault_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        term_next      = term_reg;
        deg_next       = deg_reg;
        bn_next        = bn_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        quo_next       = quo_reg;
        upper_next     = upper_reg;
        cnt_next       = cnt_reg;
        bits_next      = bits_reg;
        rbits_next     = rbits_reg;
        sbits_next     = sbits_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        it_next        = it_reg;
        dir_next       = dir_reg;
        res_next       = res_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bn_next   = in_cat[VB-1:0];
                    deg_next  = (cfg_deg_reg < DEG_MIN) ? DEG_MIN : cfg_deg_reg;
                    opb_next  = in_cat[VB-1:0];
                    bits_next = CNT_W'(VB);
                    cur_next  = '0;
                    dir_next  = 1'b0;
                    if (in_cat[VB-1:0] == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // leading zero count, one bit a cycle
                if (opb_reg[VB-1])
                begin
                    bits_next  = bits_reg + CNT_W'(deg_reg) - CNT_W'(1);
                    rbits_next = '0;
                    state_next = ST_RBITS;
                end
                else
                begin
                    opb_next  = {opb_reg[VB-2:0], 1'b0};
                    bits_next = bits_reg - CNT_W'(1);
                end
            end

            ST_RBITS:
            begin
                // ceiling divide of the bit length by the degree
                if (bits_reg >= CNT_W'(deg_reg))
                begin
                    bits_next  = bits_reg - CNT_W'(deg_reg);
                    rbits_next = rbits_reg + CNT_W'(1);
                end
                else
                begin
                    sbits_next = sb_min;
                    k_next     = sb_min - SB_W'(1);
                    cnt_next   = amt_wide[CNT_W-1:0];
                    upper_next = bn_reg;
                    state_next = ST_SHR;
                end
            end

            ST_SHR:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    upper_next = {1'b0, upper_reg[VB-1:1]};
                    cnt_next   = cnt_reg - CNT_W'(1);
                end
            end

            ST_SEARCH:
            begin
                opa_next   = cur_reg | (VB'(1) << k_reg);
                opb_next   = VB'(1);
                acc_next   = '0;
                cnt_next   = CNT_W'(VB - 1);
                j_next     = deg_reg;
                state_next = ST_POW_MUL;
            end

            ST_POW_MUL:
            begin
                acc_next = mul_step;
                opb_next = {opb_reg[VB-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    j_next = j_reg - DEG_BITS'(1);
                    if (j_reg == DEG_BITS'(1))
                    begin
                        state_next = ST_POW_CHK;
                    end
                    else
                    begin
                        opb_next = mul_step;
                        acc_next = '0;
                        cnt_next = CNT_W'(VB - 1);
                    end
                end
            end

            ST_POW_CHK:
            begin
                cur_next = pow_cur;
                if (k_reg == '0)
                begin
                    if (rbits_reg == CNT_W'(sbits_reg))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cnt_next   = rbits_reg - CNT_W'(sbits_reg);
                        state_next = ST_SHL;
                    end
                end
                else
                begin
                    k_next     = k_reg - SB_W'(1);
                    state_next = ST_SEARCH;
                end
            end

            ST_SHL:
            begin
                if (cnt_reg == '0)
                begin
                    it_next    = '0;
                    term_next  = TERM_NONE;
                    state_next = ST_DEN_INIT;
                end
                else
                begin
                    cur_next = {cur_reg[VB-2:0], 1'b0};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end

            ST_DEN_INIT:
            begin
                if (it_reg == IT_W'(MAX_ITERATIONS))
                begin
                    dir_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    opa_next   = cur_reg;
                    opb_next   = VB'(1);
                    acc_next   = '0;
                    cnt_next   = CNT_W'(VB - 1);
                    j_next     = deg_reg - DEG_BITS'(1);
                    state_next = ST_DEN_MUL;
                end
            end

            ST_DEN_MUL:
            begin
                acc_next = mul_step;
                opb_next = {opb_reg[VB-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    j_next = j_reg - DEG_BITS'(1);
                    if (j_reg == DEG_BITS'(1))
                    begin
                        if (mul_step == '0)
                        begin
                            dir_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            opa_next   = mul_step;
                            opb_next   = bn_reg;
                            acc_next   = '0;
                            quo_next   = '0;
                            cnt_next   = CNT_W'(VB - 1);
                            state_next = ST_DIV_Q;
                        end
                    end
                    else
                    begin
                        opb_next = mul_step;
                        acc_next = '0;
                        cnt_next = CNT_W'(VB - 1);
                    end
                end
            end

            ST_DIV_Q:
            begin
                acc_next = div_rem;
                quo_next = div_quo;
                opb_next = {opb_reg[VB-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_CMP;
                end
            end

            ST_CMP:
            begin
                if (cur_reg == quo_reg)
                begin
                    dir_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    dir_next   = (cur_reg > quo_reg);
                    opb_next   = (cur_reg > quo_reg) ? (cur_reg - quo_reg)
                                                     : (quo_reg - cur_reg);
                    state_next = ST_STEP;
                end
            end

            ST_STEP:
            begin
                // estimate above the quotient moves down, below moves up
                if (dir_reg && term_reg == TERM_UP)
                begin
                    cur_next   = cur_reg - VB'(1);
                    dir_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (!dir_reg && term_reg == TERM_DOWN)
                begin
                    state_next = ST_FINISH;
                end
                else if (opb_reg <= deg_ext)
                begin
                    cur_next   = dir_reg ? (cur_reg - VB'(1)) : (cur_reg + VB'(1));
                    term_next  = dir_reg ? TERM_DOWN : TERM_UP;
                    it_next    = it_reg + IT_W'(1);
                    state_next = ST_DEN_INIT;
                end
                else
                begin
                    opa_next   = deg_ext;
                    acc_next   = '0;
                    quo_next   = '0;
                    cnt_next   = CNT_W'(VB - 1);
                    state_next = ST_DIV_D;
                end
            end

            ST_DIV_D:
            begin
                acc_next = div_rem;
                quo_next = div_quo;
                opb_next = {opb_reg[VB-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    cur_next   = dir_reg ? (cur_reg - div_quo) : (cur_reg + div_quo);
                    term_next  = TERM_NONE;
                    it_next    = it_reg + IT_W'(1);
                    state_next = ST_DEN_INIT;
                end
            end

            ST_FINISH:
            begin
                // dir marks a zero divisor when reached from the multiply
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    fault_next     = dir_reg;
                    res_next       = dir_reg ? '0 : cur_wide[ROOT_BITS-1:0];
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_fault |-> root_low == '0 && root_high == '0)
        else $error("fault result carries a non-zero root");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        it_reg <= IT_W'(MAX_ITERATIONS))
        else $error("newton step count past its limit");

    a_deg_min: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DEN_INIT |-> deg_reg >= DEG_MIN)
        else $error("degree below two in newton loop");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && out_valid && !out_ready |=> state_reg == ST_FINISH)
        else $error("result written over a waiting transfer");

endmodule
